@@ hdl/kruskal_spanning_tree_macros.svh @@
// Assertion macros used by the block's datapath module.
`ifndef KRUSKAL_SPANNING_TREE_MACROS_SVH
`define KRUSKAL_SPANNING_TREE_MACROS_SVH
`ifndef SYNTHESIS
// Condition must hold at every clock edge out of reset.
`define KST_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("kst check failed");
// Consequent must hold in the cycle after the antecedent.
`define KST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kst check failed");
`else
`define KST_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define KST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ hdl/kst_pkg.sv @@
package kst_pkg;

  // Fixed field widths.
  localparam int VTX_W        = 5;
  localparam int WGT_W        = 16;
  localparam int TOT_W        = 21;
  localparam int VCNT_W       = 6;
  localparam int MAX_VERTICES = 32;
  localparam int EDGE_W       = WGT_W + 2 * VTX_W;
  localparam logic [VCNT_W-1:0] VCNT_RESET = 6'd32;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_START,
    ST_SCAN,
    ST_SCAN_END,
    ST_CHECK,
    ST_FIND_A,
    ST_FIND_B,
    ST_PUSH,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan_clr;
    logic scan_rd;
    logic find_init;
    logic find_step;
    logic find_a_done;
    logic reject;
    logic union_go;
    logic push;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic run_empty;
    logic scan_at_end;
    logic best_vld;
    logic root_done;
    logic same_set;
    logic out_free;
    logic pending_vld;
    logic at_limit;
  } status_t;

endpackage

@@ hdl/kst_ram.sv @@
module kst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hdl/kst_ctrl.sv @@
module kst_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tlast,
  input  kst_pkg::status_t sts,
  output kst_pkg::cmd_t    cmd,
  output logic             in_tready
);
  import kst_pkg::*;

  state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        in_tready = 1'b1;
        cmd.load  = 1'b1;
        if (in_tvalid && in_tlast) begin
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        if (sts.run_empty) begin
          state_nxt = ST_FINISH;
        end else begin
          cmd.scan_clr = 1'b1;
          state_nxt    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.scan_at_end) begin
          state_nxt = ST_SCAN_END;
        end
      end
      ST_SCAN_END: begin
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts.best_vld) begin
          cmd.find_init = 1'b1;
          state_nxt     = ST_FIND_A;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FIND_A: begin
        if (sts.root_done) begin
          cmd.find_a_done = 1'b1;
          state_nxt       = ST_FIND_B;
        end else begin
          cmd.find_step = 1'b1;
        end
      end
      ST_FIND_B: begin
        if (!sts.root_done) begin
          cmd.find_step = 1'b1;
        end else if (sts.same_set) begin
          cmd.reject   = 1'b1;
          cmd.scan_clr = 1'b1;
          state_nxt    = ST_SCAN;
        end else begin
          cmd.union_go = 1'b1;
          state_nxt    = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!sts.pending_vld || sts.out_free) begin
          cmd.push = 1'b1;
          if (sts.at_limit) begin
            state_nxt = ST_FINISH;
          end else begin
            cmd.scan_clr = 1'b1;
            state_nxt    = ST_SCAN;
          end
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

endmodule

@@ hdl/kst_dpath.sv @@
`include "kruskal_spanning_tree_macros.svh"
module kst_dpath #(
  parameter int MAX_EDGES = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  kst_pkg::cmd_t                   cmd,
  output kst_pkg::status_t                sts,
  input  logic                            in_tvalid,
  input  logic [31:0]                     in_tdata,
  input  logic                            cfg_wr_en,
  input  logic [kst_pkg::VCNT_W-1:0]      cfg_wr_data,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [47:0]                     out_tdata,
  output logic                            out_tlast,
  output logic [1:0]                      out_tuser
);
  import kst_pkg::*;

  localparam int AW = $clog2(MAX_EDGES);
  localparam int CW = $clog2(MAX_EDGES + 1);

  // Configuration and graph bookkeeping.
  logic [VCNT_W-1:0] vcnt_r;
  logic [CW-1:0]     count_r;
  logic              ovf_r;
  logic [VCNT_W-1:0] nv;
  logic [VCNT_W-1:0] limit;
  logic [VCNT_W-1:0] acc_r;

  // Scan state: previous and best (weight, index) keys.
  logic [AW-1:0]           scan_idx_r;
  logic                    rd_vld_r;
  logic [AW-1:0]           rd_idx_r;
  logic [EDGE_W-1:0]       rd_data;
  logic                    prev_vld_r;
  logic signed [WGT_W-1:0] prev_w_r;
  logic [AW-1:0]           prev_idx_r;
  logic                    best_vld_r;
  logic signed [WGT_W-1:0] best_w_r;
  logic [AW-1:0]           best_idx_r;
  logic [VTX_W-1:0]        best_a_r;
  logic [VTX_W-1:0]        best_b_r;

  // Union-find.
  logic [VTX_W-1:0] parent_r [MAX_VERTICES];
  logic [VTX_W-1:0] root_r;
  logic [VTX_W-1:0] ra_r;
  logic signed [TOT_W-1:0] total_r;

  // Pending result held back until it is known whether it is the final one.
  logic                    pend_vld_r;
  logic [47:0]             pend_data_r;

  // Output register.
  logic        out_vld_r;
  logic [47:0] out_data_r;
  logic        out_last_r;
  logic [1:0]  out_user_r;

  logic [VTX_W-1:0]        in_from;
  logic [VTX_W-1:0]        in_to;
  logic signed [WGT_W-1:0] in_w;
  logic                    in_fire;
  logic                    in_range;
  logic                    wr_en;
  logic signed [WGT_W-1:0] rd_w;
  logic                    gt_prev;
  logic                    lt_best;
  logic                    take;
  logic                    out_free;
  logic [47:0]             new_item;

  assign in_from  = in_tdata[VTX_W-1:0];
  assign in_to    = in_tdata[2*VTX_W-1:VTX_W];
  assign in_w     = in_tdata[EDGE_W-1:2*VTX_W];
  assign in_fire  = cmd.load && in_tvalid;
  assign nv       = (vcnt_r > VCNT_W'(MAX_VERTICES)) ? VCNT_W'(MAX_VERTICES) : vcnt_r;
  assign limit    = (nv != '0) ? nv - 1'b1 : '0;
  assign in_range = ({1'b0, in_from} < nv) && ({1'b0, in_to} < nv);
  assign wr_en    = in_fire && in_range && (count_r < CW'(MAX_EDGES));

  kst_ram #(
    .WIDTH(EDGE_W),
    .DEPTH(MAX_EDGES)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (in_tdata[EDGE_W-1:0]),
    .rd_en   (cmd.scan_rd),
    .rd_addr (scan_idx_r),
    .rd_data (rd_data)
  );

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcnt_r <= VCNT_RESET;
    end else if (cfg_wr_en) begin
      vcnt_r <= cfg_wr_data;
    end
  end

  // Key comparison: next edge after the previous one in (weight, index) order.
  assign rd_w    = rd_data[EDGE_W-1:2*VTX_W];
  assign gt_prev = !prev_vld_r || (rd_w > prev_w_r) ||
                   ((rd_w == prev_w_r) && (rd_idx_r > prev_idx_r));
  assign lt_best = !best_vld_r || (rd_w < best_w_r) ||
                   ((rd_w == best_w_r) && (rd_idx_r < best_idx_r));
  assign take    = rd_vld_r && gt_prev && lt_best;

  assign out_free = !out_vld_r || out_tready;
  assign new_item = {1'b0, total_r, best_w_r, best_b_r, best_a_r};

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      ovf_r      <= 1'b0;
      acc_r      <= '0;
      rd_vld_r   <= 1'b0;
      prev_vld_r <= 1'b0;
      best_vld_r <= 1'b0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
      scan_idx_r <= '0;
      total_r    <= '0;
      for (int i = 0; i < MAX_VERTICES; i++) begin
        parent_r[i] <= VTX_W'(i);
      end
    end else begin
      rd_vld_r <= cmd.scan_rd;
      // Edge loading.
      if (wr_en) begin
        count_r <= count_r + 1'b1;
      end else if (in_fire && in_range) begin
        ovf_r <= 1'b1;
      end
      // Scan address.
      if (cmd.scan_clr) begin
        scan_idx_r <= '0;
        best_vld_r <= 1'b0;
      end else if (cmd.scan_rd) begin
        scan_idx_r <= scan_idx_r + 1'b1;
      end
      if (take) begin
        best_vld_r <= 1'b1;
      end
      if (cmd.reject || cmd.union_go) begin
        prev_vld_r <= 1'b1;
      end
      // Merge the sets and accumulate.
      if (cmd.union_go) begin
        parent_r[root_r] <= ra_r;
        total_r          <= total_r + TOT_W'(best_w_r);
        acc_r            <= acc_r + 1'b1;
      end
      // Result transactions.
      if ((cmd.push && pend_vld_r) || cmd.finish) begin
        out_vld_r <= 1'b1;
      end else if (out_vld_r && out_tready) begin
        out_vld_r <= 1'b0;
      end
      if (cmd.push) begin
        pend_vld_r <= 1'b1;
      end
      if (cmd.finish) begin
        count_r    <= '0;
        ovf_r      <= 1'b0;
        acc_r      <= '0;
        prev_vld_r <= 1'b0;
        pend_vld_r <= 1'b0;
        total_r    <= '0;
        for (int i = 0; i < MAX_VERTICES; i++) begin
          parent_r[i] <= VTX_W'(i);
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    rd_idx_r <= scan_idx_r;
    if (take) begin
      best_w_r   <= rd_w;
      best_idx_r <= rd_idx_r;
      best_a_r   <= rd_data[VTX_W-1:0];
      best_b_r   <= rd_data[2*VTX_W-1:VTX_W];
    end
    if (cmd.reject || cmd.union_go) begin
      prev_w_r   <= best_w_r;
      prev_idx_r <= best_idx_r;
    end
    // Root walk.
    if (cmd.find_init) begin
      root_r <= best_a_r;
    end else if (cmd.find_a_done) begin
      ra_r   <= root_r;
      root_r <= best_b_r;
    end else if (cmd.find_step) begin
      root_r <= parent_r[root_r];
    end
    if (cmd.push) begin
      pend_data_r <= new_item;
      if (pend_vld_r) begin
        out_data_r <= pend_data_r;
        out_last_r <= 1'b0;
        out_user_r <= {ovf_r, 1'b0};
      end
    end
    if (cmd.finish) begin
      out_data_r <= pend_vld_r ? pend_data_r : '0;
      out_last_r <= 1'b1;
      out_user_r <= {ovf_r, !pend_vld_r};
    end
  end

  assign sts.run_empty   = (count_r == '0) || (limit == '0);
  assign sts.scan_at_end = (CW'(scan_idx_r) == count_r - 1'b1);
  assign sts.best_vld    = best_vld_r;
  assign sts.root_done   = (parent_r[root_r] == root_r);
  assign sts.same_set    = (ra_r == root_r);
  assign sts.out_free    = out_free;
  assign sts.pending_vld = pend_vld_r;
  assign sts.at_limit    = (acc_r == limit);

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

  // The store count never passes its depth.
  `KST_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_r <= CW'(MAX_EDGES))
  // A held result implies at least one accepted edge.
  `KST_ASSERT_ALWAYS(a_pend_acc, clk, rst_n, !pend_vld_r || (acc_r != '0))
  // Closing a run clears the graph and presents a final result.
  `KST_ASSERT_NEXT(a_finish_clear, clk, rst_n, cmd.finish,
                   (count_r == '0) && !pend_vld_r && out_vld_r && out_last_r)

endmodule

@@ hdl/kruskal_spanning_tree.sv @@
// Loading: one edge per cycle; the input is ready only while no run is in progress.
// Run: one store scan per pick in (weight, arrival) order, then a walk of parent hops
// from each endpoint of the picked edge; output stalls can hold a run up.
// Synchronous active-low reset clears the graph and sets vertex_count to 32.
module kruskal_spanning_tree #(
  parameter int MAX_EDGES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: edge_from[4:0], edge_to[9:5], edge_weight[25:10], zero fill
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        in_tlast,
  // out_tdata: tree_from[4:0], tree_to[9:5], tree_weight[25:10],
  // total_weight[46:26], zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,
  output logic        out_tlast,
  // out_tuser: tree_empty[0], edges_dropped[1]
  output logic [1:0]  out_tuser,
  input  logic        cfg_wr_en,
  input  logic [kst_pkg::VCNT_W-1:0] cfg_wr_data
);
  import kst_pkg::*;

  cmd_t    cmd;
  status_t sts;

  kst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .sts       (sts),
    .cmd       (cmd),
    .in_tready (in_tready)
  );

  kst_dpath #(
    .MAX_EDGES(MAX_EDGES)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_tvalid   (in_tvalid),
    .in_tdata    (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser)
  );

endmodule

@@ bench/kruskal_spanning_tree_checker.sv @@
`timescale 1ns / 100ps

module kruskal_spanning_tree_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,
  input  logic        out_tlast,
  input  logic [1:0]  out_tuser,
  input  logic        cfg_wr_en,
  input  logic [kst_pkg::VCNT_W-1:0] cfg_wr_data,
  output int          fail_count,
  output int          tree_edges_pending,
  output int          edges_seen,
  output int          trees_seen
);
  import kst_pkg::*;

  localparam int STORE_DEPTH = 64;

  typedef struct packed {
    logic              empty;
    logic              dropped;
    logic              last;
    logic [TOT_W-1:0]  total;
    logic [WGT_W-1:0]  weight;
    logic [VTX_W-1:0]  to;
    logic [VTX_W-1:0]  from;
  } tree_item_t;

  // Shadow copy of the block's graph state.
  logic [VCNT_W-1:0] vtx_count;
  logic [VTX_W-1:0]  graph_from [STORE_DEPTH];
  logic [VTX_W-1:0]  graph_to   [STORE_DEPTH];
  logic signed [WGT_W-1:0] graph_wgt [STORE_DEPTH];
  int                graph_size;
  logic              graph_overflow;
  int                uf_parent [MAX_VERTICES];
  tree_item_t        tree_queue [$];

  function automatic int uf_root(int x);
    int r;
    int n;
    r = x;
    while (uf_parent[r] != r) r = uf_parent[r];
    while (uf_parent[x] != r) begin
      n = uf_parent[x];
      uf_parent[x] = r;
      x = n;
    end
    return r;
  endfunction

  // Sort the stored graph stably by weight and run the union-find walk.
  task automatic build_tree();
    int order [STORE_DEPTH];
    int i;
    int j;
    int ra;
    int rb;
    int nv;
    int limit;
    int taken;
    logic signed [TOT_W-1:0] run_total;
    tree_item_t item;
    nv = (vtx_count > MAX_VERTICES) ? MAX_VERTICES : vtx_count;
    limit = (nv > 0) ? nv - 1 : 0;
    taken = 0;
    run_total = '0;
    for (i = 0; i < graph_size; i++) begin
      j = i;
      while (j > 0 && graph_wgt[order[j-1]] > graph_wgt[i]) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = i;
    end
    for (i = 0; i < MAX_VERTICES; i++) uf_parent[i] = i;
    for (i = 0; i < graph_size && taken < limit; i++) begin
      ra = uf_root(graph_from[order[i]]);
      rb = uf_root(graph_to[order[i]]);
      if (ra != rb) begin
        uf_parent[rb] = ra;
        run_total = run_total + TOT_W'(graph_wgt[order[i]]);
        item = '0;
        item.from = graph_from[order[i]];
        item.to = graph_to[order[i]];
        item.weight = graph_wgt[order[i]];
        item.total = run_total;
        item.dropped = graph_overflow;
        tree_queue = {tree_queue, item};
        taken++;
      end
    end
    if (taken == 0) begin
      item = '0;
      item.last = 1'b1;
      item.empty = 1'b1;
      item.dropped = graph_overflow;
      tree_queue = {tree_queue, item};
    end else begin
      tree_queue[$].last = 1'b1;
    end
    graph_size = 0;
    graph_overflow = 1'b0;
  endtask

  assign tree_edges_pending = tree_queue.size();

  always @(posedge clk) begin
    tree_item_t got;
    tree_item_t want;
    logic [VTX_W-1:0] a;
    logic [VTX_W-1:0] b;
    int nv;
    if (!rst_n) begin
      vtx_count <= VCNT_RESET;
      graph_size = 0;
      graph_overflow = 1'b0;
      tree_queue.delete();
      fail_count <= 0;
      edges_seen <= 0;
      trees_seen <= 0;
    end else begin
      // Result transaction compared with the oldest expected tree edge.
      if (out_tvalid && out_tready) begin
        got = '0;
        {got.total, got.weight, got.to, got.from} = out_tdata[46:0];
        got.last = out_tlast;
        got.empty = out_tuser[0];
        got.dropped = out_tuser[1];
        if (tree_queue.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = tree_queue.pop_front();
          if (got !== want || out_tdata[47] !== 1'b0) begin
            $display("%0t: mismatch expected from=%0d to=%0d w=%0d tot=%0d l=%b e=%b d=%b",
                     $time, want.from, want.to, $signed(want.weight),
                     $signed(want.total), want.last, want.empty, want.dropped);
            $display("%0t:          actual from=%0d to=%0d w=%0d tot=%0d l=%b e=%b d=%b",
                     $time, got.from, got.to, $signed(got.weight),
                     $signed(got.total), got.last, got.empty, got.dropped);
            fail_count <= fail_count + 1;
          end
          if (want.last) trees_seen <= trees_seen + 1;
        end
      end
      // Edge transaction: store or drop, then run on the last edge.
      if (in_tvalid && in_tready) begin
        a = in_tdata[4:0];
        b = in_tdata[9:5];
        nv = (vtx_count > MAX_VERTICES) ? MAX_VERTICES : vtx_count;
        if (a < nv && b < nv) begin
          if (graph_size < STORE_DEPTH) begin
            graph_from[graph_size] = a;
            graph_to[graph_size] = b;
            graph_wgt[graph_size] = in_tdata[25:10];
            graph_size++;
          end else begin
            graph_overflow = 1'b1;
          end
        end
        edges_seen <= edges_seen + 1;
        if (in_tlast) build_tree();
      end
      if (cfg_wr_en) vtx_count <= cfg_wr_data;
    end
  end
endmodule

@@ bench/kruskal_spanning_tree_tb.sv @@
`timescale 1ns / 100ps

module kruskal_spanning_tree_tb;
  import kst_pkg::*;

  localparam int STALL_LIMIT = 60000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic        out_tlast;
  logic [1:0]  out_tuser;
  logic        cfg_wr_en;
  logic [VCNT_W-1:0] cfg_wr_data;
  int          fail_count;
  int          tree_edges_pending;
  int          edges_seen;
  int          trees_seen;
  int          send_idle_pct;
  int          recv_stall_pct;
  logic        hold_off;
  int          edges_sent;
  int          idle_cycles;

  kruskal_spanning_tree u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  kruskal_spanning_tree_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .fail_count(fail_count), .tree_edges_pending(tree_edges_pending),
    .edges_seen(edges_seen), .trees_seen(trees_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver: random stalls, or a long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog on cycles with no transaction on either channel.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("status: fail");
      $finish;
    end
  end

  // Offer one edge, with random sender gaps, until it is taken. The valid
  // stays up after the transaction; the next edge or the drain replaces it.
  task automatic send_edge(input logic [4:0] a, input logic [4:0] b,
                           input logic [15:0] w, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, w, b, a};
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    edges_sent++;
  endtask

  // Wait for all expected results, plus a margin for a run with no output yet.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tree_edges_pending != 0 || !in_tready) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_vertices(input logic [VCNT_W-1:0] n);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= n;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Random graph: mostly in-range endpoints, a few out of range.
  task automatic random_graph(input int n_edges, input int nv);
    int i;
    logic [4:0] a;
    logic [4:0] b;
    logic [15:0] w;
    for (i = 0; i < n_edges; i++) begin
      if ($urandom_range(9) == 0) begin
        a = 5'($urandom);
        b = 5'($urandom);
      end else begin
        a = 5'($urandom_range(nv > 0 ? nv - 1 : 0));
        b = 5'($urandom_range(nv > 0 ? nv - 1 : 0));
      end
      case ($urandom_range(3))
        0: w = 16'($urandom_range(7));
        1: w = 16'($urandom);
        default: w = 16'($urandom_range(200) - 100);
      endcase
      send_edge(a, b, w, i == n_edges - 1);
    end
  endtask

  initial begin
    int phase;
    int nv;
    int k;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    hold_off = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    edges_sent = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extreme weights and endpoints, ties and a self loop.
    send_edge(5'd31, 5'd0, 16'h7fff, 1'b0);
    send_edge(5'd0, 5'd31, 16'h8000, 1'b0);
    send_edge(5'd3, 5'd3, 16'h8000, 1'b0);
    send_edge(5'd1, 5'd2, 16'h0005, 1'b0);
    send_edge(5'd2, 5'd4, 16'h0005, 1'b0);
    send_edge(5'd1, 5'd4, 16'h0005, 1'b0);
    send_edge(5'd30, 5'd29, 16'hffff, 1'b1);
    drain();
    // Only a self loop: empty tree.
    send_edge(5'd7, 5'd7, 16'h1234, 1'b1);
    drain();
    // Four vertices: edges beyond the count are skipped; the tree stops at three.
    set_vertices(6'd4);
    send_edge(5'd4, 5'd0, 16'h0001, 1'b0);
    send_edge(5'd0, 5'd1, 16'h0010, 1'b0);
    send_edge(5'd1, 5'd2, 16'h0010, 1'b0);
    send_edge(5'd2, 5'd3, 16'h0010, 1'b0);
    send_edge(5'd0, 5'd3, 16'h0001, 1'b1);
    drain();
    // Zero and one vertex, and a count above the maximum.
    set_vertices(6'd0);
    send_edge(5'd0, 5'd0, 16'h0001, 1'b1);
    drain();
    set_vertices(6'd1);
    send_edge(5'd0, 5'd0, 16'h0002, 1'b1);
    drain();
    set_vertices(6'd63);
    send_edge(5'd31, 5'd30, 16'h4000, 1'b1);
    drain();

    // Store overflow: 66 in-range edges, then a long receiver hold-off timed
    // in its own process while the sender keeps offering the next graphs.
    set_vertices(6'd32);
    random_graph(66, 32);
    fork
      begin
        hold_off <= 1'b1;
        repeat (400) @(posedge clk);
        hold_off <= 1'b0;
      end
    join_none
    random_graph(6, 32);
    random_graph(3, 32);
    drain();

    // Random phases with varied idling and vertex counts.
    phase = 0;
    while (edges_sent < 270) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      case ($urandom_range(4))
        0: nv = 2;
        1: nv = 32;
        default: nv = $urandom_range(3, 12);
      endcase
      set_vertices(nv[VCNT_W-1:0]);
      for (k = 0; k < 3; k++) begin
        random_graph($urandom_range(1, 12), nv);
        if ($urandom_range(1) == 0) drain();
      end
      drain();
      phase++;
    end

    drain();
    $display("Covered %0d edge transactions and %0d spanning trees,", edges_seen, trees_seen);
    $display("with vertex counts 0 to 63, store overflow and receiver hold-off.");
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
